[src/pp2rgb_pkg.sv]
// ----------------------------------------------------------------------------
// pp2rgb_pkg: pixel format codes and color conversion functions
// Shared types, color constants and byte-to-pixel conversions for the packed
// pixel to RGB888 converter.
// ----------------------------------------------------------------------------
`default_nettype none

package pp2rgb_pkg;

  // Pixel format codes; codes 6 and 7 carry no meaning and drop the byte
  typedef enum logic [2:0] {
    FMT_RGB565    = 3'd0,
    FMT_BINARY    = 3'd1,
    FMT_SEGMENTED = 3'd2,
    FMT_GRAY8     = 3'd3,
    FMT_FEATURE16 = 3'd4,
    FMT_RANK6     = 3'd5
  } pix_fmt_e;

  typedef logic [23:0] rgb_t;

  // Segmented color table entries
  localparam rgb_t COL_BLACK   = 24'h000000;
  localparam rgb_t COL_RED     = 24'hFF0000;
  localparam rgb_t COL_YELLOW  = 24'hFFFF00;
  localparam rgb_t COL_GREEN   = 24'h00FF00;
  localparam rgb_t COL_CYAN    = 24'h00FFFF;
  localparam rgb_t COL_BLUE    = 24'h0000FF;
  localparam rgb_t COL_MAGENTA = 24'hFF00FF;
  localparam rgb_t COL_WHITE   = 24'hFFFFFF;
  localparam rgb_t COL_GREY    = 24'h808080;

  // Replicate one byte into all three channels
  function automatic rgb_t grey_of(input logic [7:0] v);
    return {v, v, v};
  endfunction

  // Expand 5-6-5 to 8-8-8, low bits of each channel zero
  function automatic rgb_t from_rgb565(input logic [7:0] hi, input logic [7:0] lo);
    return {hi[7:3], 3'b000, hi[2:0], lo[7:5], 2'b00, lo[4:0], 3'b000};
  endfunction

  // First non-zero nibble in the order white, red, green, blue
  function automatic rgb_t from_feature16(input logic [7:0] hi, input logic [7:0] lo);
    rgb_t px;
    px = '0;
    if (hi[7:4] != 4'd0) begin
      px = grey_of({hi[7:4], 4'd0});
    end else if (hi[3:0] != 4'd0) begin
      px = {hi[3:0], 4'd0, 16'd0};
    end else if (lo[7:4] != 4'd0) begin
      px = {8'd0, lo[7:4], 4'd0, 8'd0};
    end else begin
      px = {16'd0, lo[3:0], 4'd0};
    end
    return px;
  endfunction

  // One-hot byte to eight colors, anything else grey
  function automatic rgb_t from_segmented(input logic [7:0] v);
    rgb_t px;
    case (v)
      8'h01:   px = COL_BLACK;
      8'h02:   px = COL_RED;
      8'h04:   px = COL_YELLOW;
      8'h08:   px = COL_GREEN;
      8'h10:   px = COL_CYAN;
      8'h20:   px = COL_BLUE;
      8'h40:   px = COL_MAGENTA;
      8'h80:   px = COL_WHITE;
      default: px = COL_GREY;
    endcase
    return px;
  endfunction

endpackage

`default_nettype wire

[src/packed_pixel_to_rgb888.sv]
// ----------------------------------------------------------------------------
// packed_pixel_to_rgb888: camera byte stream to 24-bit RGB pixels
// Converts payload bytes into RGB888 pixels following the configured format.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one payload byte per beat
//   plus frame_start_i, which restarts byte pairing at the first frame byte.
//   Output channel (out_valid_o / out_ready_i) carries one pixel per beat.
//   Config channel (cfg_valid_i / cfg_ready_o) writes the pixel format and is
//   always ready; the user writes it only while the block is idle, and the
//   block itself does not enforce this. Paired formats (rgb565, feature16)
//   give one pixel per two bytes; the others give one pixel per byte;
//   formats 6 and 7 drop the byte.
//   Path: the input register takes the byte when it is accepted, and the
//   result register takes the pixel made from it when stage one advances.
//   Throughput: one byte per cycle while the output is not stalled, set by the single conversion stage.
//   Stall: when the receiver holds out_ready_i low, the result register holds
//   its pixel, and in_ready_o drops as soon as the input register also holds
//   a byte that makes a pixel.
//   Reset: format rgb565, pairing phase cleared, both registers empty.
// ----------------------------------------------------------------------------
`default_nettype none

module packed_pixel_to_rgb888
  import pp2rgb_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_pixel_format_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        frame_start_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [23:0]      pixel_rgb_o
);

  pix_fmt_e    fmt_q;
  logic        s1_valid_q;
  logic [7:0]  s1_byte_q;
  logic        s1_start_q;
  logic        pair_phase_q, pair_phase_d;
  logic [7:0]  held_byte_q, held_byte_d;
  logic        out_valid_q;
  rgb_t        pixel_q;
  rgb_t        pixel_d;
  logic        paired;
  logic        phase_eff;
  logic        produce;
  logic        out_free;
  logic        s1_adv;
  logic        in_fire;

  assign cfg_ready_o = 1'b1;

  // Hold the format register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= FMT_RGB565;
    end else if (cfg_valid_i) begin
      fmt_q <= pix_fmt_e'(cfg_pixel_format_i);
    end
  end

  // Advance stage one when the result register has room or nothing is made
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && (out_free || !produce);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q  <= data_byte_i;
      s1_start_q <= frame_start_i;
    end
  end

  // Pair bytes and convert the current byte
  assign paired    = (fmt_q == FMT_RGB565) || (fmt_q == FMT_FEATURE16);
  assign phase_eff = pair_phase_q && !s1_start_q;

  always_comb begin
    pair_phase_d = 1'b0;
    held_byte_d  = held_byte_q;
    produce      = 1'b1;
    pixel_d      = '0;
    case (fmt_q)
      FMT_RGB565, FMT_FEATURE16: begin
        if (!phase_eff) begin
          held_byte_d  = s1_byte_q;
          pair_phase_d = 1'b1;
          produce      = 1'b0;
        end else if (fmt_q == FMT_RGB565) begin
          pixel_d = from_rgb565(held_byte_q, s1_byte_q);
        end else begin
          pixel_d = from_feature16(held_byte_q, s1_byte_q);
        end
      end
      FMT_BINARY:    pixel_d = (s1_byte_q != 8'd0) ? COL_WHITE : COL_BLACK;
      FMT_SEGMENTED: pixel_d = from_segmented(s1_byte_q);
      FMT_GRAY8:     pixel_d = grey_of(s1_byte_q);
      FMT_RANK6:     pixel_d = grey_of({s1_byte_q[5:0], 2'b00});
      default:       produce = 1'b0;
    endcase
  end

  // Update pairing state as each byte leaves stage one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_phase_q <= 1'b0;
      held_byte_q  <= 8'd0;
    end else if (s1_adv) begin
      pair_phase_q <= pair_phase_d;
      held_byte_q  <= held_byte_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && produce) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && produce) begin
      pixel_q <= pixel_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_rgb_o = pixel_q;

  // Input stalls only when both registers are full
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_q))
    else $error("input stalled with a free register");

  // A frame start byte in a paired format never completes a pixel
  a_start_no_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_start_q && paired) |-> !produce)
    else $error("frame start byte completed a pair");

  // A single-byte format leaves pairing cleared
  a_single_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && !paired) |=> !pair_phase_q)
    else $error("pair phase kept in a single-byte format");

  // A paired pixel needs a held first byte
  a_pair_needs_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && paired && produce) |-> pair_phase_q)
    else $error("paired pixel without a held byte");

  // A loaded result shows on the output in the next cycle
  a_result_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && produce) |=> out_valid_q)
    else $error("result register did not load");

endmodule

`default_nettype wire
